// File: design/nmea_gga_rmc_field_parser_macros.svh
`ifndef NMEA_GGA_RMC_FIELD_PARSER_MACROS_SVH
`define NMEA_GGA_RMC_FIELD_PARSER_MACROS_SVH

// same-cycle implication
`define NGRP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define NGRP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/ngrp_pkg.sv
package ngrp_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_W     = 8'h57;
  localparam logic [7:0] CH_A     = 8'h41;

  localparam logic [2:0] HDR_LEN  = 3'd6;
  localparam logic [2:0] HDR_SKIP = 3'd6;
  localparam logic [2:0] HDR_BODY = 3'd7;

  typedef enum logic [3:0] {
    FC_HOUR    = 4'd0,
    FC_MIN     = 4'd1,
    FC_SEC     = 4'd2,
    FC_LAT     = 4'd3,
    FC_LON     = 4'd4,
    FC_VALID   = 4'd5,
    FC_SATS    = 4'd6,
    FC_HDOP    = 4'd7,
    FC_ALT     = 4'd8,
    FC_SPEED   = 4'd9,
    FC_HEADING = 4'd10,
    FC_DAY     = 4'd11,
    FC_MONTH   = 4'd12,
    FC_YEAR    = 4'd13
  } field_code_e;

  typedef struct packed {
    logic [7:0] ch;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [3:0]         field_code;
    logic signed [31:0] field_value;
    logic               run_last;
  } out_item_t;

  // triple: three records with codes code..code+2 and values from bytes 0..2
  typedef struct packed {
    logic        triple;
    logic [3:0]  code;
    logic [31:0] value;
  } rec_cmd_t;

  typedef struct packed {
    logic full;
    logic not_empty;
  } q_stat_t;

  function automatic logic [7:0] hdr_gga(input logic [2:0] idx);
    logic [7:0] c;
    unique case (idx)
      3'd0:    c = 8'h24;
      3'd1:    c = 8'h47;
      3'd2:    c = 8'h50;
      3'd3:    c = 8'h47;
      3'd4:    c = 8'h47;
      3'd5:    c = 8'h41;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] hdr_rmc(input logic [2:0] idx);
    logic [7:0] c;
    unique case (idx)
      3'd0:    c = 8'h24;
      3'd1:    c = 8'h47;
      3'd2:    c = 8'h50;
      3'd3:    c = 8'h52;
      3'd4:    c = 8'h4D;
      3'd5:    c = 8'h43;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// File: design/nmea_gga_rmc_field_parser.sv
// A byte that closes a field queues a command; the record expander then registers its first
// record. One byte per cycle while full is low; records leave at one per cycle while pop_i
// is high, three for a time or date. The command queue between parser and record expander
// sets how long a burst may back up before full rises; full depends only on that queue.
// Reset (rst_ni low, asynchronous) returns the parser to the header and empties all queues.
`include "nmea_gga_rmc_field_parser_macros.svh"

module nmea_gga_rmc_field_parser #(
  parameter int unsigned QUEUE_DEPTH = ngrp_pkg::QUEUE_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ngrp_pkg::in_item_t  in_i,
  input  logic                push_i,
  output logic                full_o,
  output ngrp_pkg::out_item_t out_o,
  output logic                empty_o,
  input  logic                pop_i
);
  import ngrp_pkg::*;

  rec_cmd_t cmd_wr, cmd_rd;
  q_stat_t  q_stat;
  logic     cmd_push, cmd_pop, accept;

  assign full_o = q_stat.full;
  assign accept = push_i && !q_stat.full;

  ngrp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .in_i       (in_i),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_wr)
  );

  ngrp_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .wdata_i (cmd_wr),
    .pop_i   (cmd_pop),
    .rdata_o (cmd_rd),
    .stat_o  (q_stat)
  );

  ngrp_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd_rd),
    .stat_i    (q_stat),
    .cmd_pop_o (cmd_pop),
    .out_o     (out_o),
    .empty_o   (empty_o),
    .pop_i     (pop_i)
  );

  `NGRP_ASSERT_NOW(a_code_range, !empty_o, out_o.field_code <= FC_YEAR, "field code out of range")
  `NGRP_ASSERT_NEXT(a_burst_cont, pop_i && !empty_o && !out_o.run_last, !empty_o, "record burst broken")
  `NGRP_ASSERT_NEXT(a_burst_code, pop_i && !empty_o && !out_o.run_last, out_o.field_code == $past(out_o.field_code) + 4'd1, "burst code not consecutive")

endmodule

// File: design/ngrp_front.sv
module ngrp_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  ngrp_pkg::in_item_t in_i,
  output logic               cmd_push_o,
  output ngrp_pkg::rec_cmd_t cmd_o
);
  import ngrp_pkg::*;

  typedef struct packed {
    logic [2:0]      cnt;
    logic [31:0]     acc;
    logic            stop;
    logic [7:0]      first;
    logic [2:0][7:0] pair;
  } fld_t;

  logic [2:0]  hdr_q, hdr_d;
  logic [1:0]  match_q, match_d;
  logic [3:0]  fnum_q, fnum_d;
  logic [31:0] coord_q, coord_d;
  fld_t        fld_q, fld_d;

  fld_t        add_fld, cls_fld;
  logic [7:0]  dig;
  logic        is_comma, in_body, do_add, do_close;
  logic        gga, rmc;
  logic [31:0] coord_neg;

  always_comb begin
    add_fld = fld_q;
    dig     = in_i.ch - CH_ZERO;
    if (fld_q.cnt == 3'd0) begin
      add_fld.first = in_i.ch;
    end
    if (fld_q.cnt < 3'd6) begin
      for (int i = 0; i < 3; i++) begin
        if (fld_q.cnt[2:1] == 2'(i)) begin
          if (!fld_q.cnt[0]) begin
            add_fld.pair[i] = 8'((dig << 3) + (dig << 1));
          end else begin
            add_fld.pair[i] = fld_q.pair[i] + dig;
          end
        end
      end
    end
    if (!fld_q.stop) begin
      if (in_i.ch >= CH_ZERO && in_i.ch <= CH_NINE) begin
        add_fld.acc = (fld_q.acc << 3) + (fld_q.acc << 1) + {24'd0, dig};
      end else if (in_i.ch != CH_DOT) begin
        add_fld.stop = 1'b1;
      end
    end
    if (fld_q.cnt != 3'd7) begin
      add_fld.cnt = fld_q.cnt + 3'd1;
    end
  end

  assign is_comma = (in_i.ch == CH_COMMA);
  assign in_body  = (hdr_q == HDR_BODY);
  assign do_add   = accept_i && in_body && !is_comma;
  assign do_close = accept_i && in_body && (is_comma || in_i.last_byte);
  assign cls_fld  = is_comma ? fld_q : add_fld;
  assign gga      = match_q[0];
  assign rmc      = match_q[1];
  assign coord_neg = 32'd0 - coord_q;

  always_comb begin
    cmd_push_o   = 1'b0;
    cmd_o.triple = 1'b0;
    cmd_o.code   = FC_HOUR;
    cmd_o.value  = cls_fld.acc;
    coord_d      = coord_q;
    if (do_close && (gga || rmc)) begin
      if (fnum_q == 4'd0) begin
        cmd_push_o   = 1'b1;
        cmd_o.triple = 1'b1;
        cmd_o.code   = FC_HOUR;
        cmd_o.value  = {8'd0, cls_fld.pair[2], cls_fld.pair[1], cls_fld.pair[0]};
      end else if (gga) begin
        unique case (fnum_q)
          4'd1, 4'd3: coord_d = cls_fld.acc;
          4'd2: begin
            cmd_push_o  = 1'b1;
            cmd_o.code  = FC_LAT;
            cmd_o.value = (cls_fld.first == CH_S) ? coord_neg : coord_q;
          end
          4'd4: begin
            cmd_push_o  = 1'b1;
            cmd_o.code  = FC_LON;
            cmd_o.value = (cls_fld.first == CH_W) ? coord_neg : coord_q;
          end
          4'd5: begin
            cmd_push_o  = 1'b1;
            cmd_o.code  = FC_VALID;
            cmd_o.value = {31'd0, cls_fld.first != CH_ZERO};
          end
          4'd6: begin
            cmd_push_o  = 1'b1;
            cmd_o.code  = FC_SATS;
            cmd_o.value = {24'd0, cls_fld.pair[0]};
          end
          4'd7: begin
            cmd_push_o = 1'b1;
            cmd_o.code = FC_HDOP;
          end
          4'd8: begin
            cmd_push_o = 1'b1;
            cmd_o.code = FC_ALT;
          end
          default: ;
        endcase
      end else begin
        unique case (fnum_q)
          4'd1: begin
            cmd_push_o  = 1'b1;
            cmd_o.code  = FC_VALID;
            cmd_o.value = {31'd0, cls_fld.first == CH_A};
          end
          4'd2, 4'd4: coord_d = cls_fld.acc;
          4'd3: begin
            cmd_push_o  = 1'b1;
            cmd_o.code  = FC_LAT;
            cmd_o.value = (cls_fld.first == CH_S) ? coord_neg : coord_q;
          end
          4'd5: begin
            cmd_push_o  = 1'b1;
            cmd_o.code  = FC_LON;
            cmd_o.value = (cls_fld.first == CH_W) ? coord_neg : coord_q;
          end
          4'd6: begin
            cmd_push_o = 1'b1;
            cmd_o.code = FC_SPEED;
          end
          4'd7: begin
            cmd_push_o = 1'b1;
            cmd_o.code = FC_HEADING;
          end
          4'd8: begin
            cmd_push_o   = 1'b1;
            cmd_o.triple = 1'b1;
            cmd_o.code   = FC_DAY;
            cmd_o.value  = {8'd0, cls_fld.pair[2], cls_fld.pair[1], cls_fld.pair[0]};
          end
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    hdr_d   = hdr_q;
    match_d = match_q;
    fnum_d  = fnum_q;
    fld_d   = fld_q;
    if (accept_i) begin
      if (hdr_q < HDR_LEN) begin
        if (in_i.ch != hdr_gga(hdr_q)) match_d[0] = 1'b0;
        if (in_i.ch != hdr_rmc(hdr_q)) match_d[1] = 1'b0;
        hdr_d = hdr_q + 3'd1;
      end else if (hdr_q == HDR_SKIP) begin
        hdr_d = HDR_BODY;
      end
      if (do_add) begin
        fld_d = add_fld;
      end
      if (do_close) begin
        fld_d = '0;
        if (fnum_q != 4'd15) begin
          fnum_d = fnum_q + 4'd1;
        end
      end
      if (in_i.last_byte) begin
        hdr_d   = '0;
        match_d = 2'b11;
        fnum_d  = '0;
        fld_d   = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_q   <= '0;
      match_q <= 2'b11;
      fnum_q  <= '0;
      coord_q <= '0;
      fld_q   <= '0;
    end else begin
      hdr_q   <= hdr_d;
      match_q <= match_d;
      fnum_q  <= fnum_d;
      fld_q   <= fld_d;
      coord_q <= (accept_i && in_i.last_byte) ? 32'd0 : coord_d;
    end
  end

endmodule

// File: design/ngrp_fifo.sv
module ngrp_fifo #(
  parameter int unsigned DEPTH = ngrp_pkg::QUEUE_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  ngrp_pkg::rec_cmd_t wdata_i,
  input  logic               pop_i,
  output ngrp_pkg::rec_cmd_t rdata_o,
  output ngrp_pkg::q_stat_t  stat_o
);
  import ngrp_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  rec_cmd_t            mem_q [DEPTH];
  logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]     cnt_q;
  logic                do_push, do_pop;

  assign stat_o.full      = (cnt_q == CntW'(DEPTH));
  assign stat_o.not_empty = (cnt_q != '0);
  assign do_push          = push_i && !stat_o.full;
  assign do_pop           = pop_i && stat_o.not_empty;
  assign rdata_o          = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// File: design/ngrp_back.sv
module ngrp_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ngrp_pkg::rec_cmd_t  cmd_i,
  input  ngrp_pkg::q_stat_t   stat_i,
  output logic                cmd_pop_o,
  output ngrp_pkg::out_item_t out_o,
  output logic                empty_o,
  input  logic                pop_i
);
  import ngrp_pkg::*;

  logic [1:0] idx_q;
  logic       valid_q;
  out_item_t  out_q, rec;
  logic       load, last_rec;
  logic [7:0] pair_byte;

  assign last_rec = !cmd_i.triple || (idx_q == 2'd2);
  assign load     = stat_i.not_empty && (!valid_q || pop_i);
  assign cmd_pop_o = load && last_rec;

  always_comb begin
    case (idx_q)
      2'd0:    pair_byte = cmd_i.value[7:0];
      2'd1:    pair_byte = cmd_i.value[15:8];
      default: pair_byte = cmd_i.value[23:16];
    endcase
    rec.field_code  = cmd_i.code + {2'd0, idx_q};
    rec.field_value = cmd_i.triple ? {24'd0, pair_byte} : cmd_i.value;
    rec.run_last    = last_rec;
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= rec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        idx_q   <= last_rec ? 2'd0 : idx_q + 2'd1;
      end else if (pop_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  assign out_o   = out_q;
  assign empty_o = !valid_q;

endmodule

// File: sim/tb_nmea_gga_rmc_field_parser.sv
`timescale 1ns / 100ps

module tb_nmea_gga_rmc_field_parser;
  import ngrp_pkg::*;

  localparam int CLK_PERIOD   = 20;
  localparam int SENT_ITEMS   = 230;
  localparam int DRAIN_CYCLES = 20;

  localparam int MATCH_GGA = 0;
  localparam int MATCH_RMC = 1;

  localparam logic [3:0] POS_TIME  = 4'd0;
  localparam logic [3:0] GGA_LAT   = 4'd1;
  localparam logic [3:0] GGA_NS    = 4'd2;
  localparam logic [3:0] GGA_LON   = 4'd3;
  localparam logic [3:0] GGA_EW    = 4'd4;
  localparam logic [3:0] GGA_FIX   = 4'd5;
  localparam logic [3:0] GGA_SATS  = 4'd6;
  localparam logic [3:0] GGA_HDOP  = 4'd7;
  localparam logic [3:0] GGA_ALT   = 4'd8;
  localparam logic [3:0] RMC_STAT  = 4'd1;
  localparam logic [3:0] RMC_LAT   = 4'd2;
  localparam logic [3:0] RMC_NS    = 4'd3;
  localparam logic [3:0] RMC_LON   = 4'd4;
  localparam logic [3:0] RMC_EW    = 4'd5;
  localparam logic [3:0] RMC_SPD   = 4'd6;
  localparam logic [3:0] RMC_HDG   = 4'd7;
  localparam logic [3:0] RMC_DATE  = 4'd8;
  localparam logic [3:0] FIELD_SAT = 4'd15;
  localparam logic [2:0] CHAR_SAT  = 3'd7;
  localparam logic [2:0] PAIR_CHARS = 3'd6;

  class nmea_record_board;
    out_item_t   want_q[$];
    out_item_t   burst[$];
    int          errors;
    logic [2:0]  hdr_pos;
    logic [1:0]  cand;
    logic [3:0]  fld;
    logic [2:0]  nchar;
    logic [31:0] acc;
    logic        halt;
    logic [7:0]  first_ch;
    logic [7:0]  pairs[3];
    logic [31:0] coord;

    function new();
      errors = 0;
      restart();
    endfunction

    function void clear_field();
      nchar = '0;
      acc = '0;
      halt = 1'b0;
      first_ch = '0;
      foreach (pairs[k]) pairs[k] = '0;
    endfunction

    function void restart();
      hdr_pos = '0;
      cand = 2'b11;
      fld = '0;
      coord = '0;
      clear_field();
    endfunction

    function void emit(field_code_e code, logic [31:0] value);
      out_item_t r;
      r.field_code = code;
      r.field_value = value;
      r.run_last = 1'b0;
      burst.push_back(r);
    endfunction

    function void emit_triple(field_code_e c0, field_code_e c1, field_code_e c2);
      emit(c0, {24'd0, pairs[0]});
      emit(c1, {24'd0, pairs[1]});
      emit(c2, {24'd0, pairs[2]});
    endfunction

    function logic [31:0] hemi(logic [7:0] neg_ch);
      return (first_ch == neg_ch) ? -coord : coord;
    endfunction

    function logic [7:0] tag_char(bit rmc, logic [2:0] idx);
      string tag;
      if (rmc) tag = "$GPRMC";
      else tag = "$GPGGA";
      return tag[idx];
    endfunction

    function void close_field();
      if (cand[MATCH_GGA] || cand[MATCH_RMC]) begin
        if (fld == POS_TIME) begin
          emit_triple(FC_HOUR, FC_MIN, FC_SEC);
        end else if (cand[MATCH_GGA]) begin
          case (fld)
            GGA_LAT, GGA_LON: coord = acc;
            GGA_NS:   emit(FC_LAT, hemi(CH_S));
            GGA_EW:   emit(FC_LON, hemi(CH_W));
            GGA_FIX:  emit(FC_VALID, (first_ch != CH_ZERO) ? 32'd1 : 32'd0);
            GGA_SATS: emit(FC_SATS, {24'd0, pairs[0]});
            GGA_HDOP: emit(FC_HDOP, acc);
            GGA_ALT:  emit(FC_ALT, acc);
            default: ;
          endcase
        end else begin
          case (fld)
            RMC_STAT: emit(FC_VALID, (first_ch == CH_A) ? 32'd1 : 32'd0);
            RMC_LAT, RMC_LON: coord = acc;
            RMC_NS:   emit(FC_LAT, hemi(CH_S));
            RMC_EW:   emit(FC_LON, hemi(CH_W));
            RMC_SPD:  emit(FC_SPEED, acc);
            RMC_HDG:  emit(FC_HEADING, acc);
            RMC_DATE: emit_triple(FC_DAY, FC_MONTH, FC_YEAR);
            default: ;
          endcase
        end
      end
      if (fld != FIELD_SAT) fld++;
      clear_field();
    endfunction

    function void add_char(logic [7:0] c);
      logic [7:0] d;
      d = c - CH_ZERO;
      if (nchar == 3'd0) first_ch = c;
      if (nchar < PAIR_CHARS) begin
        if (!nchar[0]) pairs[nchar[2:1]] = d * 8'd10;
        else pairs[nchar[2:1]] = pairs[nchar[2:1]] + d;
      end
      if (!halt) begin
        if (c >= CH_ZERO && c <= CH_NINE) acc = acc * 32'd10 + {24'd0, d};
        else if (c != CH_DOT) halt = 1'b1;
      end
      if (nchar != CHAR_SAT) nchar++;
    endfunction

    function void note_input(in_item_t item);
      burst.delete();
      if (hdr_pos < HDR_LEN) begin
        if (item.ch != tag_char(1'b0, hdr_pos)) cand[MATCH_GGA] = 1'b0;
        if (item.ch != tag_char(1'b1, hdr_pos)) cand[MATCH_RMC] = 1'b0;
        hdr_pos++;
      end else if (hdr_pos == HDR_SKIP) begin
        hdr_pos = HDR_BODY;
      end else if (item.ch == CH_COMMA) begin
        close_field();
      end else begin
        add_char(item.ch);
        if (item.last_byte) close_field();
      end
      if (burst.size() > 0) burst[burst.size() - 1].run_last = 1'b1;
      foreach (burst[k]) want_q.push_back(burst[k]);
      if (item.last_byte) restart();
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (want_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected record, expected none, actual code %0d value %0d last %0b",
                 $time, got.field_code, got.field_value, got.run_last);
        return;
      end
      want = want_q.pop_front();
      if (got.field_code !== want.field_code) begin
        errors++;
        $display("%0t: field_code expected %0d actual %0d",
                 $time, want.field_code, got.field_code);
      end
      if (got.field_value !== want.field_value) begin
        errors++;
        $display("%0t: field_value (code %0d) expected %0d actual %0d",
                 $time, want.field_code, want.field_value, got.field_value);
      end
      if (got.run_last !== want.run_last) begin
        errors++;
        $display("%0t: run_last (code %0d) expected %0b actual %0b",
                 $time, want.field_code, want.run_last, got.run_last);
      end
    endfunction

    function int pending();
      return want_q.size();
    endfunction
  endclass

  logic      clk_i = 1'b0;
  logic      rst_ni;
  in_item_t  in_i;
  logic      push_i;
  logic      full_o;
  out_item_t out_o;
  logic      empty_o;
  logic      pop_i;

  nmea_record_board records;
  logic [7:0] line_q[$];
  int         sent_cnt;
  int         burst_left;

  nmea_gga_rmc_field_parser u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .push_i  (push_i),
    .full_o  (full_o),
    .out_o   (out_o),
    .empty_o (empty_o),
    .pop_i   (pop_i)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  task automatic send_byte(logic [7:0] c, logic last);
    in_item_t item;
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        push_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 24);
    end
    item.ch = c;
    item.last_byte = last;
    in_i <= item;
    push_i <= 1'b1;
    do @(posedge clk_i); while (full_o);
    records.note_input(item);
    burst_left--;
    sent_cnt++;
  endtask

  task automatic send_line();
    foreach (line_q[k]) send_byte(line_q[k], k == line_q.size() - 1);
    line_q.delete();
  endtask

  function automatic void put_text(string s);
    foreach (s[k]) line_q.push_back(s[k]);
  endfunction

  function automatic void put_field(int pos, bit rmc);
    string hemi_set;
    string flag_set;
    int kind;
    int len;
    hemi_set = "NSEW";
    flag_set = "0126AV";
    kind = $urandom_range(0, 9);
    if (kind == 0) return;
    if (kind == 1) begin
      len = $urandom_range(1, 8);
      repeat (len) line_q.push_back(8'($urandom_range(0, 255)));
      return;
    end
    if (rmc ? (pos == RMC_NS || pos == RMC_EW) : (pos == GGA_NS || pos == GGA_EW)) begin
      line_q.push_back(hemi_set[$urandom_range(0, 3)]);
      return;
    end
    if (rmc ? (pos == RMC_STAT) : (pos == GGA_FIX)) begin
      line_q.push_back(flag_set[$urandom_range(0, 5)]);
      return;
    end
    len = (kind == 2) ? $urandom_range(9, 14) : $urandom_range(1, 6);
    for (int k = 0; k < len; k++) begin
      if (k > 0 && $urandom_range(0, 7) == 0) line_q.push_back(CH_DOT);
      else line_q.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
    end
    if (kind == 3) line_q.push_back(8'($urandom_range(8'h41, 8'h5A)));
  endfunction

  function automatic void put_sentence();
    int kind;
    int nf;
    bit rmc;
    kind = $urandom_range(0, 9);
    if (kind == 9) begin
      nf = $urandom_range(1, 10);
      repeat (nf) line_q.push_back(8'($urandom_range(0, 255)));
      return;
    end
    rmc = (kind == 8) ? 1'($urandom_range(0, 1)) : (kind >= 4);
    if (rmc) put_text("$GPRMC");
    else put_text("$GPGGA");
    if (kind == 8) line_q[$urandom_range(0, 5)] = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 7) == 0) line_q.push_back(8'($urandom_range(0, 255)));
    else line_q.push_back(CH_COMMA);
    nf = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 18) : $urandom_range(9, 10);
    for (int p = 0; p < nf; p++) begin
      if (p > 0) line_q.push_back(CH_COMMA);
      put_field(p, rmc);
    end
    if ($urandom_range(0, 1) == 1) line_q.push_back(CH_COMMA);
  endfunction

  initial begin
    records = new();
    rst_ni = 1'b0;
    push_i = 1'b0;
    in_i = '0;
    sent_cnt = 0;
    burst_left = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    put_text("$GP");
    send_line();
    line_q.push_back(8'h00);
    line_q.push_back(8'hFF);
    send_line();
    put_text("$GPGGA,,9,S,.5,W,0,");
    send_line();
    put_text("$GPRMC,,A,");
    send_line();

    while (sent_cnt < SENT_ITEMS) begin
      put_sentence();
      send_line();
    end
    push_i <= 1'b0;

    while (records.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (records.errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin
    int rx_cyc;
    rx_cyc = 0;
    pop_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && pop_i && !empty_o) records.check_result(out_o);
      rx_cyc++;
      case ((rx_cyc / 50) % 4)
        0: pop_i <= 1'b1;
        1: pop_i <= 1'($urandom_range(0, 1));
        2: pop_i <= ($urandom_range(0, 3) == 0);
        default: pop_i <= ((rx_cyc % 50) >= 30);
      endcase
    end
  end

  initial begin
    #(CLK_PERIOD * 200000);
    $display("status: fail");
    $finish;
  end

endmodule
